// ----- design/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg: shared types for the midpoint ellipse rasterizer
// Defaults, datapath command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mer_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 12;

    // multiplier operand pair select
    typedef enum logic [3:0] {
        MUL_AA,       // semi_a * semi_a
        MUL_BB,       // semi_b * semi_b
        MUL_A2_B,     // a^2 * semi_b
        MUL_B2_X1,    // b^2 * (x+1)
        MUL_A2_2Y1,   // a^2 * (2y-1)
        MUL_B2_2X3,   // b^2 * (2x+3)
        MUL_A2_Y,     // a^2 * y
        MUL_HX_HX,    // (2x+1)^2
        MUL_YM_YM,    // (y-1)^2
        MUL_B2_T,     // b^2 * temp
        MUL_A2_DEC,   // a^2 * decision
        MUL_A2_B2     // a^2 * b^2
    } mul_sel_t;

    // register writeback select, uses the product from the previous cycle
    typedef enum logic [3:0] {
        WB_NONE,
        WB_LOAD,      // take corners from the input word
        WB_A2,
        WB_B2,
        WB_D1,        // initial region 1 decision
        WB_T_LHS,     // temp = 2*prod
        WB_T_TX,      // temp = 4*prod
        WB_R1_UPD,    // region 1 iteration
        WB_T_PROD,    // temp = prod
        WB_DEC_PROD,  // decision = prod
        WB_T_ACC,     // temp += 4*prod
        WB_D2,        // decision = temp - 4*prod
        WB_T_8,       // temp = 8*prod
        WB_R2_UPD     // region 2 iteration
    } wb_sel_t;

    // controller to datapath
    typedef struct packed {
        mul_sel_t    mul_sel;
        wb_sel_t     wb_sel;
        logic        pt_load;
        logic [1:0]  pt_idx;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lhs_lt;   // region 1 slope test: temp < prod
        logic y_zero;   // pos_y == 0
    } dp_status_t;

endpackage

// ----- design/mer_ctrl.sv -----
// ----------------------------------------------------------------------------
// mer_ctrl: sequencer for the ellipse rasterizer
// Steps the shared multiplier through load, region 1, region switch and
// region 2 sequences, tracks the drawing phase and paces the four-point run.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 op_step,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output mer_pkg::dp_cmd_t     cmd,
    input  mer_pkg::dp_status_t  status
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L1, ST_L2, ST_L3, ST_L4,
        ST_S1, ST_S2, ST_S3, ST_S4, ST_S5,
        ST_W4, ST_W5, ST_W6, ST_W7, ST_W8,
        ST_R0, ST_R1, ST_R2,
        ST_PT0, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_R1, PH_R2, PH_DONE
    } phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic        m_tvalid_reg;
    logic [1:0]  beat_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // command decode
    always_comb begin
        cmd.mul_sel = MUL_AA;
        cmd.wb_sel  = WB_NONE;
        cmd.pt_load = 1'b0;
        cmd.pt_idx  = 2'd0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !op_step) begin
                    cmd.wb_sel = WB_LOAD;
                end
            end
            ST_L1: cmd.mul_sel = MUL_AA;
            ST_L2: begin
                cmd.wb_sel  = WB_A2;
                cmd.mul_sel = MUL_BB;
            end
            ST_L3: begin
                cmd.wb_sel  = WB_B2;
                cmd.mul_sel = MUL_A2_B;
            end
            ST_L4: cmd.wb_sel = WB_D1;
            ST_S1: cmd.mul_sel = MUL_B2_X1;
            ST_S2: begin
                cmd.wb_sel  = WB_T_LHS;
                cmd.mul_sel = MUL_A2_2Y1;
            end
            ST_S3: cmd.mul_sel = status.lhs_lt ? MUL_B2_2X3 : MUL_HX_HX;
            ST_S4: begin
                cmd.wb_sel  = WB_T_TX;
                cmd.mul_sel = MUL_A2_Y;
            end
            ST_S5: cmd.wb_sel = WB_R1_UPD;
            ST_W4: begin
                cmd.wb_sel  = WB_T_PROD;
                cmd.mul_sel = MUL_YM_YM;
            end
            ST_W5: begin
                cmd.wb_sel  = WB_DEC_PROD;
                cmd.mul_sel = MUL_B2_T;
            end
            ST_W6: begin
                cmd.wb_sel  = WB_T_PROD;
                cmd.mul_sel = MUL_A2_DEC;
            end
            ST_W7: begin
                cmd.wb_sel  = WB_T_ACC;
                cmd.mul_sel = MUL_A2_B2;
            end
            ST_W8: cmd.wb_sel = WB_D2;
            ST_R0: cmd.mul_sel = MUL_B2_X1;
            ST_R1: begin
                cmd.wb_sel  = WB_T_8;
                cmd.mul_sel = MUL_A2_Y;
            end
            ST_R2: cmd.wb_sel = WB_R2_UPD;
            ST_PT0: begin
                cmd.pt_load = 1'b1;
                cmd.pt_idx  = 2'd0;
            end
            ST_EMIT: begin
                cmd.pt_load = m_tready && (beat_reg != 2'd3);
                cmd.pt_idx  = beat_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // state, phase and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            m_tvalid_reg <= 1'b0;
            beat_reg     <= 2'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!op_step) begin
                            state_reg <= ST_L1;
                        end else if (phase_reg == PH_R1) begin
                            state_reg <= ST_S1;
                        end else if (phase_reg == PH_R2) begin
                            state_reg <= ST_R0;
                        end
                    end
                end
                ST_L1: state_reg <= ST_L2;
                ST_L2: state_reg <= ST_L3;
                ST_L3: state_reg <= ST_L4;
                ST_L4: begin
                    phase_reg <= PH_R1;
                    state_reg <= ST_PT0;
                end
                ST_S1: state_reg <= ST_S2;
                ST_S2: state_reg <= ST_S3;
                ST_S3: state_reg <= status.lhs_lt ? ST_S4 : ST_W4;
                ST_S4: state_reg <= ST_S5;
                ST_S5: state_reg <= ST_PT0;
                ST_W4: state_reg <= ST_W5;
                ST_W5: state_reg <= ST_W6;
                ST_W6: state_reg <= ST_W7;
                ST_W7: state_reg <= ST_W8;
                ST_W8: begin
                    phase_reg <= PH_R2;
                    state_reg <= ST_R0;
                end
                ST_R0: state_reg <= ST_R1;
                ST_R1: state_reg <= ST_R2;
                ST_R2: state_reg <= ST_PT0;
                ST_PT0: begin
                    // y reaching zero closes the ellipse
                    if (status.y_zero) begin
                        phase_reg <= PH_DONE;
                    end
                    m_tvalid_reg <= 1'b1;
                    beat_reg     <= 2'd0;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (beat_reg == 2'd3) begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            beat_reg <= beat_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/mer_datapath.sv -----
// ----------------------------------------------------------------------------
// mer_datapath: ellipse geometry registers and shared multiplier
// One registered multiplier feeds a writeback stage that updates the
// squares, the scaled decision and the position; a point register holds
// the word on the output channel.
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic [4*COORD_WIDTH-1:0]  corners,
    input  mer_pkg::dp_cmd_t          cmd,
    output mer_pkg::dp_status_t       status,
    output logic [COORD_WIDTH-1:0]    point_x,
    output logic [COORD_WIDTH-1:0]    point_y,
    output logic                      point_last,
    output logic                      point_done
);
    import mer_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = CW - 1;          // semi-axis and position
    localparam int SQW = 2 * SW;          // squares
    localparam int MBW = 2 * CW;          // multiplier operand B
    localparam int PRW = SQW + MBW;       // product
    localparam int DW  = 4 * SW + 6;      // scaled decision

    logic [CW-1:0]   center_x_reg, center_x_next;
    logic [CW-1:0]   center_y_reg, center_y_next;
    logic [SW-1:0]   semi_a_reg, semi_a_next;
    logic [SW-1:0]   semi_b_reg, semi_b_next;
    logic [SQW-1:0]  a_sq_reg, a_sq_next;
    logic [SQW-1:0]  b_sq_reg, b_sq_next;
    logic [SW-1:0]   pos_x_reg, pos_x_next;
    logic [SW-1:0]   pos_y_reg, pos_y_next;
    logic [DW-1:0]   dec_reg, dec_next;
    logic [DW-1:0]   tmp_reg, tmp_next;
    logic [PRW-1:0]  prod_reg, prod_next;
    logic [CW-1:0]   pt_x_reg, pt_x_next;
    logic [CW-1:0]   pt_y_reg, pt_y_next;
    logic            pt_last_reg, pt_last_next;
    logic            pt_done_reg, pt_done_next;

    // corner fields
    logic [CW-1:0] x1, y1, x2, y2;
    logic [CW:0]   sum_x, sum_y;
    logic [CW-1:0] dif_x, dif_y;

    assign x1 = corners[CW-1:0];
    assign y1 = corners[2*CW-1:CW];
    assign x2 = corners[3*CW-1:2*CW];
    assign y2 = corners[4*CW-1:3*CW];
    assign sum_x = {1'b0, x1} + {1'b0, x2};
    assign sum_y = {1'b0, y1} + {1'b0, y2};
    assign dif_x = (x1 > x2) ? (x1 - x2) : (x2 - x1);
    assign dif_y = (y1 > y2) ? (y1 - y2) : (y2 - y1);

    // multiplier operands
    logic [CW-1:0]   x_p1, y2_m1, hx;
    logic [CW:0]     x2_p3;
    logic [SW-1:0]   y_m1;
    logic [SQW-1:0]  op_a;
    logic [MBW-1:0]  op_b;

    assign x_p1  = {1'b0, pos_x_reg} + CW'(1);
    assign y2_m1 = {pos_y_reg, 1'b0} - CW'(1);
    assign hx    = {pos_x_reg, 1'b1};
    assign x2_p3 = {1'b0, pos_x_reg, 1'b0} + (CW+1)'(3);
    assign y_m1  = pos_y_reg - SW'(1);

    always_comb begin
        op_a = SQW'(semi_a_reg);
        op_b = MBW'(semi_a_reg);
        case (cmd.mul_sel)
            MUL_AA: begin
                op_a = SQW'(semi_a_reg);
                op_b = MBW'(semi_a_reg);
            end
            MUL_BB: begin
                op_a = SQW'(semi_b_reg);
                op_b = MBW'(semi_b_reg);
            end
            MUL_A2_B: begin
                op_a = a_sq_reg;
                op_b = MBW'(semi_b_reg);
            end
            MUL_B2_X1: begin
                op_a = b_sq_reg;
                op_b = MBW'(x_p1);
            end
            MUL_A2_2Y1: begin
                op_a = a_sq_reg;
                op_b = MBW'(y2_m1);
            end
            MUL_B2_2X3: begin
                op_a = b_sq_reg;
                op_b = MBW'(x2_p3);
            end
            MUL_A2_Y: begin
                op_a = a_sq_reg;
                op_b = MBW'(pos_y_reg);
            end
            MUL_HX_HX: begin
                op_a = SQW'(hx);
                op_b = MBW'(hx);
            end
            MUL_YM_YM: begin
                op_a = SQW'(y_m1);
                op_b = MBW'(y_m1);
            end
            MUL_B2_T: begin
                op_a = b_sq_reg;
                op_b = tmp_reg[MBW-1:0];
            end
            MUL_A2_DEC: begin
                op_a = a_sq_reg;
                op_b = dec_reg[MBW-1:0];
            end
            MUL_A2_B2: begin
                op_a = a_sq_reg;
                op_b = MBW'(b_sq_reg);
            end
            default: ;
        endcase
    end

    assign prod_next = PRW'(op_a) * PRW'(op_b);

    // widened operands for the decision adders
    logic [DW-1:0] prod_ext, a2_ext, b2_ext, ty;

    assign prod_ext = DW'(prod_reg);
    assign a2_ext   = DW'(a_sq_reg);
    assign b2_ext   = DW'(b_sq_reg);
    // 4a^2(3-2y), product holds a^2*y
    assign ty       = (a2_ext << 3) + (a2_ext << 2) - (prod_ext << 3);

    // writeback
    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        semi_a_next   = semi_a_reg;
        semi_b_next   = semi_b_reg;
        a_sq_next     = a_sq_reg;
        b_sq_next     = b_sq_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        dec_next      = dec_reg;
        tmp_next      = tmp_reg;
        case (cmd.wb_sel)
            WB_NONE: ;
            WB_LOAD: begin
                center_x_next = sum_x[CW:1];
                center_y_next = sum_y[CW:1];
                semi_a_next   = dif_x[CW-1:1];
                semi_b_next   = dif_y[CW-1:1];
                pos_x_next    = '0;
                pos_y_next    = dif_y[CW-1:1];
            end
            WB_A2: a_sq_next = prod_reg[SQW-1:0];
            WB_B2: b_sq_next = prod_reg[SQW-1:0];
            // 4b^2 + a^2 - 4a^2 b
            WB_D1: dec_next = (b2_ext << 2) + a2_ext - (prod_ext << 2);
            WB_T_LHS: tmp_next = prod_ext << 1;
            WB_T_TX: tmp_next = prod_ext << 2;
            WB_R1_UPD: begin
                if (dec_reg[DW-1]) begin
                    dec_next = dec_reg + tmp_reg;
                end else begin
                    dec_next   = dec_reg + tmp_reg + (a2_ext << 3) - (prod_ext << 3);
                    pos_y_next = pos_y_reg - SW'(1);
                end
                pos_x_next = pos_x_reg + SW'(1);
            end
            WB_T_PROD: tmp_next = prod_ext;
            WB_DEC_PROD: dec_next = prod_ext;
            WB_T_ACC: tmp_next = tmp_reg + (prod_ext << 2);
            WB_D2: dec_next = tmp_reg - (prod_ext << 2);
            WB_T_8: tmp_next = prod_ext << 3;
            WB_R2_UPD: begin
                if (dec_reg[DW-1]) begin
                    dec_next   = dec_reg + tmp_reg + ty;
                    pos_x_next = pos_x_reg + SW'(1);
                end else begin
                    dec_next = dec_reg + ty;
                end
                pos_y_next = pos_y_reg - SW'(1);
            end
            default: ;
        endcase
    end

    // mirrored point: idx bit 0 negates x, bit 1 negates y
    always_comb begin
        pt_x_next    = pt_x_reg;
        pt_y_next    = pt_y_reg;
        pt_last_next = pt_last_reg;
        pt_done_next = pt_done_reg;
        if (cmd.pt_load) begin
            pt_x_next    = cmd.pt_idx[0] ? (center_x_reg - CW'(pos_x_reg))
                                         : (center_x_reg + CW'(pos_x_reg));
            pt_y_next    = cmd.pt_idx[1] ? (center_y_reg - CW'(pos_y_reg))
                                         : (center_y_reg + CW'(pos_y_reg));
            pt_last_next = (cmd.pt_idx == 2'd3);
            pt_done_next = (pos_y_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        center_x_reg <= center_x_next;
        center_y_reg <= center_y_next;
        semi_a_reg   <= semi_a_next;
        semi_b_reg   <= semi_b_next;
        a_sq_reg     <= a_sq_next;
        b_sq_reg     <= b_sq_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        dec_reg      <= dec_next;
        tmp_reg      <= tmp_next;
        prod_reg     <= prod_next;
        pt_x_reg     <= pt_x_next;
        pt_y_reg     <= pt_y_next;
        pt_last_reg  <= pt_last_next;
        pt_done_reg  <= pt_done_next;
    end

    assign status.lhs_lt = (tmp_reg < prod_ext);
    assign status.y_zero = (pos_y_reg == '0);

    assign point_x    = pt_x_reg;
    assign point_y    = pt_y_reg;
    assign point_last = pt_last_reg;
    assign point_done = pt_done_reg;

endmodule

// ----- design/midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: midpoint ellipse point generator
// Loads an ellipse from two bounding-box corners and emits four mirrored
// points per midpoint iteration.
//
//   channel  | direction | tdata                            | tuser | tlast
//   ---------+-----------+----------------------------------+-------+-----------
//   s_       | in        | corner1 x,y, corner2 x,y         | op    | -
//   m_       | out       | point x,y                        | done  | 4th point
//
// Load: accept, a multiply/writeback sequence, a point load, then 4 output words.
// Region 1 step: accept, region 1 sequence, point load, 4 words; a switch step runs the
// slope test, region switch and region 2 sequences; region 2 step: region 2 sequence.
// Every sequence steps through the single shared multiplier, one product per cycle.
// A step while idle or done is accepted and gives no words.
// Output stalls hold the current word; no input is taken until the fourth word
// has gone. Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF,
    localparam int IN_TW  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // corner1_x, corner1_y, corner2_x, corner2_y
    input  logic [IN_TW-1:0]   s_tdata,
    // op
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // point_x, point_y
    output logic [OUT_TW-1:0]  m_tdata,
    output logic               m_tlast,
    // done_res
    output logic [0:0]         m_tuser
);
    import mer_pkg::*;

    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic [COORD_WIDTH-1:0]  point_x;
    logic [COORD_WIDTH-1:0]  point_y;
    logic                    point_last;
    logic                    point_done;

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_step  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mer_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .corners    (s_tdata[4*COORD_WIDTH-1:0]),
        .cmd        (cmd),
        .status     (status),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_last (point_last),
        .point_done (point_done)
    );

    assign m_tdata    = OUT_TW'({point_y, point_x});
    assign m_tlast    = point_last;
    assign m_tuser[0] = point_done;

`ifndef SYNTH
    // no new word is taken while a run is on the output
    a_no_accept_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during output run");

    // the fourth word ends the run
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output valid after last word");

    // a load always goes to the multiply sequence
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0]) |=> (!s_tready && !m_tvalid))
        else $error("load did not start the setup sequence");
`endif

endmodule
